>>> sv/linear_probe_hash_set_macros.svh
// Assertion macros for the linear probing hash set.
// Included by modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef LINEAR_PROBE_HASH_SET_MACROS_SVH
`define LINEAR_PROBE_HASH_SET_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LPHS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define LPHS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LPHS_ASSERT_IMP(label, ante, cons, msg)
`define LPHS_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

>>> sv/lphs_pkg.sv
// Shared types, constants and helper functions of the linear probing hash set.
// No dependencies; used by lphs_ram users and the top level.
package lphs_pkg;

    localparam int MAX_SLOTS     = 1024;
    localparam int SLOT_W        = $clog2(MAX_SLOTS);
    localparam int CNT_W         = SLOT_W + 1;
    localparam int MAX_KEY_BYTES = 32;
    localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
    localparam int LEN_W         = $clog2(MAX_KEY_BYTES + 1);
    localparam int KEY_BITS      = MAX_KEY_BYTES * 8;
    localparam int TAG_W         = 63;
    localparam int META_W        = TAG_W + LEN_W;
    localparam int CFG_W         = 64;
    localparam int HASH_W        = 64;

    localparam logic [3:0]        LOG2_CAP_MAX = 4'(SLOT_W);
    localparam logic [3:0]        LOG2_CAP_RST = 4'd10;
    localparam logic [HASH_W-1:0] MIX_GAMMA    = 64'h9E3779B97F4A7C15;
    localparam logic [HASH_W-1:0] MIX_MUL1     = 64'hBF58476D1CE4E5B9;
    localparam logic [HASH_W-1:0] MIX_MUL2     = 64'h94D049BB133111EB;
    localparam logic [HASH_W-1:0] FNV_OFFSET   = 64'hCBF29CE484222325;
    localparam logic [8:0]        FNV_PRIME_LO = 9'h1B3;

    typedef enum logic [1:0] {
        CMD_CONTAINS = 2'd0,
        CMD_INSERT   = 2'd1,
        CMD_ERASE    = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_NOT_FOUND = 3'd1,
        STAT_PRESENT   = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_INVALID   = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        CFG_HASH_SEED = 1'b0,
        CFG_LOG2_CAP  = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_SHIFT_READ,
        ST_SHIFT_CHECK,
        ST_ERASE_END,
        ST_DONE
    } state_t;

    // mixing sequencer phases
    localparam logic [3:0] MIX_LOAD1 = 4'd0;
    localparam logic [3:0] MIX_LOAD2 = 4'd4;
    localparam logic [3:0] MIX_FINAL = 4'd8;
    localparam logic [3:0] MIX_DONE  = 4'd9;

    // FNV-1a step: (h ^ b) * prime, prime = 2^40 + 0x1B3
    function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
        logic [HASH_W-1:0] y;
        y = h ^ {56'd0, b};
        return (y << 40) + (y * {55'd0, FNV_PRIME_LO});
    endfunction

    // compare the first len bytes of two key rows
    function automatic logic key_equal(input logic [KEY_BITS-1:0] a,
                                       input logic [KEY_BITS-1:0] b,
                                       input logic [LEN_W-1:0] len);
        logic eq;
        eq = 1'b1;
        for (int j = 0; j < MAX_KEY_BYTES; j++) begin
            if ((LEN_W'(j) < len) && (a[j*8 +: 8] != b[j*8 +: 8])) begin
                eq = 1'b0;
            end
        end
        return eq;
    endfunction

endpackage

>>> sv/lphs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lphs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> sv/linear_probe_hash_set.sv
// Hash set of byte-string keys: linear probing, backward-shift erase.
// Key bytes arrive on the item channel (valid/ready), one transfer per byte;
// the transfer with key_last set starts contains, insert or erase per cmd.
// Each non-last byte transfer applies one FNV step (one FNV step per cycle while item_ready is high).
// A last transfer with a valid key starts a probe walk: per slot visited a RAM
// read state, then a compare of tag, length and up to 32 key bytes; erase adds a
// read and a check state per slot scanned by the backward shift plus a final
// clear state, then the ST_DONE state loads the result register.
// One result transfer (status, occupied_count) per key: valid/ready.
// A waiting result does not block byte transfers of the next key; a new
// operation finishes its walk and then waits until the result register frees.
// After reset and after every configuration write the block runs a clearing
// pass over all 1024 tag entries, during which item_ready is low; the seeded
// hash start value is computed in the same pass on a shared 32x32 multiplier.
// Configuration writes are taken on any cycle.
// Depends on lphs_pkg, lphs_ram and linear_probe_hash_set_macros.svh.
`include "linear_probe_hash_set_macros.svh"

module linear_probe_hash_set (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  key_byte,
    input  logic        key_last,
    input  logic        key_empty,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  status,
    output logic [9:0]  occupied_count,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int SW = lphs_pkg::SLOT_W;
    localparam int CW = lphs_pkg::CNT_W;
    localparam int LW = lphs_pkg::LEN_W;
    localparam int KB = lphs_pkg::KEY_BITS;
    localparam int TW = lphs_pkg::TAG_W;
    localparam int MW = lphs_pkg::META_W;
    localparam int HW = lphs_pkg::HASH_W;

    lphs_pkg::state_t    state_reg, state_next;
    logic [HW-1:0]       hash_seed_reg, hash_seed_next;
    logic [3:0]          log2_cap_reg, log2_cap_next;
    logic [SW-1:0]       clr_addr_reg, clr_addr_next;
    logic [3:0]          mix_ph_reg, mix_ph_next;
    logic [HW-1:0]       mix_a_reg, mix_a_next;
    logic [HW-1:0]       mix_acc_reg, mix_acc_next;
    logic [HW-1:0]       start_reg, start_next;
    logic [HW-1:0]       run_hash_reg, run_hash_next;
    logic [LW-1:0]       in_len_reg, in_len_next;
    logic                too_long_reg, too_long_next;
    logic [KB-1:0]       key_vec_reg, key_vec_next;
    logic [TW-1:0]       h_reg, h_next;
    lphs_pkg::cmd_t      cmd_reg, cmd_next;
    logic [SW-1:0]       idx_reg, idx_next;
    logic [SW-1:0]       nxt_reg, nxt_next;
    logic [CW-1:0]       probe_cnt_reg, probe_cnt_next;
    logic [SW-1:0]       count_reg, count_next;
    lphs_pkg::status_t   res_reg, res_next;
    logic                result_valid_reg, result_valid_next;
    logic [2:0]          status_reg, status_next;
    logic [SW-1:0]       occ_reg, occ_next;

    // RAM ports
    logic                meta_we, key_we;
    logic [SW-1:0]       wr_addr, rd_addr;
    logic [MW-1:0]       meta_wdata, meta_rd;
    logic [KB-1:0]       key_wdata, key_rd;

    // shared multiplier
    logic [31:0]         mul_a, mul_b;
    logic [HW-1:0]       mul_p, mix_b, mix_x0;

    // capacity
    logic [3:0]          log2_eff;
    logic [CW-1:0]       cap, cap_m1;
    logic [SW-1:0]       mask;

    // probe helpers
    logic [TW-1:0]       rd_tag;
    logic [LW-1:0]       rd_len;
    logic                rd_empty, rd_match;
    logic [SW-1:0]       ideal, from_ideal, to_hole;
    logic                item_fire;
    logic [HW-1:0]       hash_upd;
    logic [TW-1:0]       h_new;
    logic                key_ok;

    lphs_ram #(.WIDTH(MW), .DEPTH(lphs_pkg::MAX_SLOTS)) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (wr_addr),
        .wdata (meta_wdata),
        .raddr (rd_addr),
        .rdata (meta_rd)
    );

    lphs_ram #(.WIDTH(KB), .DEPTH(lphs_pkg::MAX_SLOTS)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (wr_addr),
        .wdata (key_wdata),
        .raddr (rd_addr),
        .rdata (key_rd)
    );

    // capacity from register, clamped to the slot store
    always_comb
    begin
        log2_eff = (log2_cap_reg > lphs_pkg::LOG2_CAP_MAX) ? lphs_pkg::LOG2_CAP_MAX
                                                          : log2_cap_reg;
        cap      = CW'(1) << log2_eff;
        cap_m1   = cap - CW'(1);
        mask     = cap_m1[SW-1:0];
    end

    // seed mixing operands: partial products of a 64x64 low-half product
    always_comb
    begin
        mix_b  = (mix_ph_reg < lphs_pkg::MIX_LOAD2) ? lphs_pkg::MIX_MUL1
                                                    : lphs_pkg::MIX_MUL2;
        mix_x0 = lphs_pkg::MIX_GAMMA + hash_seed_reg;
        unique case (mix_ph_reg)
            4'd2, 4'd6:
            begin
                mul_a = mix_a_reg[63:32];
                mul_b = mix_b[31:0];
            end
            4'd3, 4'd7:
            begin
                mul_a = mix_a_reg[31:0];
                mul_b = mix_b[63:32];
            end
            default:
            begin
                mul_a = mix_a_reg[31:0];
                mul_b = mix_b[31:0];
            end
        endcase
        mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    end

    // read-data fields and compares
    always_comb
    begin
        rd_tag     = meta_rd[MW-1:LW];
        rd_len     = meta_rd[LW-1:0];
        rd_empty   = (rd_tag == '0);
        rd_match   = (rd_tag == h_reg) && (rd_len == in_len_reg)
                     && lphs_pkg::key_equal(key_rd, key_vec_reg, in_len_reg);
        ideal      = rd_tag[SW-1:0] & mask;
        from_ideal = (nxt_reg - ideal) & mask;
        to_hole    = (nxt_reg - idx_reg) & mask;
    end

    assign item_ready = (state_reg == lphs_pkg::ST_IDLE);
    assign item_fire  = item_valid && item_ready;
    assign hash_upd   = lphs_pkg::fnv_step(run_hash_reg, key_byte);

    // next state and datapath
    always_comb
    begin
        state_next        = state_reg;
        hash_seed_next    = hash_seed_reg;
        log2_cap_next     = log2_cap_reg;
        clr_addr_next     = clr_addr_reg;
        mix_ph_next       = mix_ph_reg;
        mix_a_next        = mix_a_reg;
        mix_acc_next      = mix_acc_reg;
        start_next        = start_reg;
        run_hash_next     = run_hash_reg;
        in_len_next       = in_len_reg;
        too_long_next     = too_long_reg;
        key_vec_next      = key_vec_reg;
        h_next            = h_reg;
        cmd_next          = cmd_reg;
        idx_next          = idx_reg;
        nxt_next          = nxt_reg;
        probe_cnt_next    = probe_cnt_reg;
        count_next        = count_reg;
        res_next          = res_reg;
        result_valid_next = result_valid_reg && !result_ready;
        status_next       = status_reg;
        occ_next          = occ_reg;
        meta_we           = 1'b0;
        key_we            = 1'b0;
        wr_addr           = idx_reg;
        meta_wdata        = '0;
        key_wdata         = key_vec_reg;
        rd_addr           = idx_reg;
        h_new             = '0;
        key_ok            = 1'b0;

        // seed mixing sequencer
        unique case (mix_ph_reg)
            lphs_pkg::MIX_LOAD1: mix_a_next = mix_x0 ^ (mix_x0 >> 30);
            4'd1, 4'd5:          mix_acc_next = mul_p;
            4'd2, 4'd3, 4'd6, 4'd7:
                                 mix_acc_next = mix_acc_reg + {mul_p[31:0], 32'd0};
            lphs_pkg::MIX_LOAD2: mix_a_next = mix_acc_reg ^ (mix_acc_reg >> 27);
            lphs_pkg::MIX_FINAL: start_next = lphs_pkg::FNV_OFFSET
                                              + (mix_acc_reg ^ (mix_acc_reg >> 31));
            default:             ;
        endcase
        if (mix_ph_reg != lphs_pkg::MIX_DONE)
        begin
            mix_ph_next = mix_ph_reg + 4'd1;
        end

        unique case (state_reg)
            // sweep every tag entry to empty
            lphs_pkg::ST_CLEAR:
            begin
                meta_we       = 1'b1;
                wr_addr       = clr_addr_reg;
                clr_addr_next = clr_addr_reg + SW'(1);
                if ((clr_addr_reg == SW'(lphs_pkg::MAX_SLOTS - 1))
                    && (mix_ph_reg == lphs_pkg::MIX_DONE))
                begin
                    state_next    = lphs_pkg::ST_IDLE;
                    run_hash_next = start_reg;
                    in_len_next   = '0;
                    too_long_next = 1'b0;
                end
            end

            // gather key bytes, start the operation on the last one
            lphs_pkg::ST_IDLE:
            begin
                if (item_fire)
                begin
                    if (!key_empty)
                    begin
                        if (in_len_reg < LW'(lphs_pkg::MAX_KEY_BYTES))
                        begin
                            key_vec_next[in_len_reg[lphs_pkg::KEY_IDX_W-1:0]*8 +: 8]
                                = key_byte;
                            in_len_next = in_len_reg + LW'(1);
                        end
                        else
                        begin
                            too_long_next = 1'b1;
                        end
                        run_hash_next = hash_upd;
                    end
                    if (key_last)
                    begin
                        h_new          = run_hash_next[TW-1:0];
                        h_next         = (h_new == '0) ? TW'(1) : h_new;
                        key_ok         = (in_len_next != '0) && !too_long_next;
                        idx_next       = h_next[SW-1:0] & mask;
                        probe_cnt_next = '0;
                        cmd_next       = lphs_pkg::cmd_t'(cmd);
                        state_next     = lphs_pkg::ST_DONE;
                        unique case (cmd)
                            lphs_pkg::CMD_CONTAINS, lphs_pkg::CMD_ERASE:
                            begin
                                res_next = lphs_pkg::STAT_NOT_FOUND;
                                if (key_ok)
                                begin
                                    state_next = lphs_pkg::ST_READ;
                                end
                            end
                            lphs_pkg::CMD_INSERT:
                            begin
                                res_next = lphs_pkg::STAT_INVALID;
                                if (key_ok)
                                begin
                                    state_next = lphs_pkg::ST_READ;
                                end
                            end
                            default: res_next = lphs_pkg::STAT_INVALID;
                        endcase
                    end
                end
            end

            lphs_pkg::ST_READ:
            begin
                rd_addr    = idx_reg;
                state_next = lphs_pkg::ST_CHECK;
            end

            // one probe step
            lphs_pkg::ST_CHECK:
            begin
                priority if (cmd_reg == lphs_pkg::CMD_INSERT && rd_match)
                begin
                    res_next   = lphs_pkg::STAT_PRESENT;
                    state_next = lphs_pkg::ST_DONE;
                end
                else if (cmd_reg == lphs_pkg::CMD_INSERT && rd_empty)
                begin
                    state_next = lphs_pkg::ST_DONE;
                    if ({1'b0, count_reg} >= cap_m1)
                    begin
                        res_next = lphs_pkg::STAT_FULL;
                    end
                    else
                    begin
                        meta_we    = 1'b1;
                        key_we     = 1'b1;
                        wr_addr    = idx_reg;
                        meta_wdata = {h_reg, in_len_reg};
                        key_wdata  = key_vec_reg;
                        count_next = count_reg + SW'(1);
                        res_next   = lphs_pkg::STAT_OK;
                    end
                end
                else if (cmd_reg != lphs_pkg::CMD_INSERT && rd_empty)
                begin
                    res_next   = lphs_pkg::STAT_NOT_FOUND;
                    state_next = lphs_pkg::ST_DONE;
                end
                else if (cmd_reg == lphs_pkg::CMD_CONTAINS && rd_match)
                begin
                    res_next   = lphs_pkg::STAT_OK;
                    state_next = lphs_pkg::ST_DONE;
                end
                else if (cmd_reg == lphs_pkg::CMD_ERASE && rd_match)
                begin
                    nxt_next       = (idx_reg + SW'(1)) & mask;
                    probe_cnt_next = '0;
                    state_next     = lphs_pkg::ST_SHIFT_READ;
                end
                else if (probe_cnt_reg + CW'(1) == cap)
                begin
                    res_next   = (cmd_reg == lphs_pkg::CMD_INSERT) ? lphs_pkg::STAT_FULL
                                                                   : lphs_pkg::STAT_NOT_FOUND;
                    state_next = lphs_pkg::ST_DONE;
                end
                else
                begin
                    idx_next       = (idx_reg + SW'(1)) & mask;
                    probe_cnt_next = probe_cnt_reg + CW'(1);
                    state_next     = lphs_pkg::ST_READ;
                end
            end

            lphs_pkg::ST_SHIFT_READ:
            begin
                rd_addr    = nxt_reg;
                state_next = lphs_pkg::ST_SHIFT_CHECK;
            end

            // backward shift: move an entry into the hole when allowed
            lphs_pkg::ST_SHIFT_CHECK:
            begin
                if (rd_empty)
                begin
                    state_next = lphs_pkg::ST_ERASE_END;
                end
                else
                begin
                    if (from_ideal >= to_hole)
                    begin
                        meta_we    = 1'b1;
                        key_we     = 1'b1;
                        wr_addr    = idx_reg;
                        meta_wdata = meta_rd;
                        key_wdata  = key_rd;
                        idx_next   = nxt_reg;
                    end
                    nxt_next = (nxt_reg + SW'(1)) & mask;
                    if (probe_cnt_reg + CW'(1) == cap)
                    begin
                        state_next = lphs_pkg::ST_ERASE_END;
                    end
                    else
                    begin
                        probe_cnt_next = probe_cnt_reg + CW'(1);
                        state_next     = lphs_pkg::ST_SHIFT_READ;
                    end
                end
            end

            lphs_pkg::ST_ERASE_END:
            begin
                meta_we    = 1'b1;
                wr_addr    = idx_reg;
                meta_wdata = '0;
                if (count_reg != '0)
                begin
                    count_next = count_reg - SW'(1);
                end
                res_next   = lphs_pkg::STAT_OK;
                state_next = lphs_pkg::ST_DONE;
            end

            // hand the result to the output register, restart the key
            lphs_pkg::ST_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next = 1'b1;
                    status_next       = res_reg;
                    occ_next          = count_reg;
                    run_hash_next     = start_reg;
                    in_len_next       = '0;
                    too_long_next     = 1'b0;
                    state_next        = lphs_pkg::ST_IDLE;
                end
            end

            default: state_next = lphs_pkg::ST_CLEAR;
        endcase

        // configuration write restarts the table
        if (cfg_we)
        begin
            unique case (lphs_pkg::cfg_idx_t'(cfg_index))
                lphs_pkg::CFG_HASH_SEED: hash_seed_next = cfg_data;
                lphs_pkg::CFG_LOG2_CAP:  log2_cap_next  = cfg_data[3:0];
                default:                 ;
            endcase
            state_next    = lphs_pkg::ST_CLEAR;
            clr_addr_next = '0;
            mix_ph_next   = lphs_pkg::MIX_LOAD1;
            count_next    = '0;
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lphs_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_seed_reg    <= '0;
            log2_cap_reg     <= lphs_pkg::LOG2_CAP_RST;
            clr_addr_reg     <= '0;
            mix_ph_reg       <= lphs_pkg::MIX_LOAD1;
            in_len_reg       <= '0;
            too_long_reg     <= 1'b0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
            probe_cnt_reg    <= '0;
        end
        else
        begin
            hash_seed_reg    <= hash_seed_next;
            log2_cap_reg     <= log2_cap_next;
            clr_addr_reg     <= clr_addr_next;
            mix_ph_reg       <= mix_ph_next;
            in_len_reg       <= in_len_next;
            too_long_reg     <= too_long_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
            probe_cnt_reg    <= probe_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mix_a_reg    <= mix_a_next;
        mix_acc_reg  <= mix_acc_next;
        start_reg    <= start_next;
        run_hash_reg <= run_hash_next;
        key_vec_reg  <= key_vec_next;
        h_reg        <= h_next;
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        nxt_reg      <= nxt_next;
        res_reg      <= res_next;
        status_reg   <= status_next;
        occ_reg      <= occ_next;
    end

    assign result_valid   = result_valid_reg;
    assign status         = status_reg;
    assign occupied_count = occ_reg;

    // checks
    `LPHS_ASSERT_IMP(a_count_below_cap, 1'b1, ({1'b0, count_reg} < cap),
        "stored count reached capacity")
    `LPHS_ASSERT_NXT(a_cfg_clears, cfg_we, (state_reg == lphs_pkg::ST_CLEAR),
        "configuration write did not start the clearing pass")
    `LPHS_ASSERT_IMP(a_probe_bound,
        (state_reg == lphs_pkg::ST_CHECK || state_reg == lphs_pkg::ST_SHIFT_CHECK),
        (probe_cnt_reg < cap), "probe walk ran past capacity")
    `LPHS_ASSERT_NXT(a_result_loaded,
        (state_reg == lphs_pkg::ST_DONE && (!result_valid_reg || result_ready) && !cfg_we),
        (result_valid_reg && state_reg == lphs_pkg::ST_IDLE),
        "finished operation did not load the result register")

endmodule
